FILE: src/dqvs_pkg.sv
package dqvs_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 9;
  localparam int OCC_W    = 9;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 56;

  localparam logic [VALUE_W-1:0] VALUE_NONE = '1;
  localparam logic [POS_W-1:0]   POS_NONE   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FRONT  = 3'd0,
    CMD_ADD_BACK   = 3'd1,
    CMD_TAKE_FRONT = 3'd2,
    CMD_TAKE_BACK  = 3'd3,
    CMD_SEARCH     = 3'd4
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic pop_capture;
    logic search_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_read;
    logic need_search;
    logic search_end;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/dqvs_ram.sv
module dqvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/dqvs_ctrl.sv
module dqvs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  dqvs_pkg::dp_status_t  dp_status,
  output dqvs_pkg::dp_cmd_t     dp_cmd
);
  import dqvs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (dp_status.need_read) state_next = S_POP;
        else if (dp_status.need_search) state_next = S_SEARCH;
        else state_next = S_DONE;
      end
      S_POP: state_next = S_DONE;
      S_SEARCH: begin
        if (dp_status.search_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (dp_status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    dp_cmd   = '0;
    case (state)
      S_IDLE: begin
        s_tready       = 1'b1;
        dp_cmd.load_in = s_tvalid;
      end
      S_EXEC:   dp_cmd.exec        = 1'b1;
      S_POP:    dp_cmd.pop_capture = 1'b1;
      S_SEARCH: dp_cmd.search_step = 1'b1;
      S_DONE:   dp_cmd.load_out    = dp_status.out_free;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/dqvs_dp.sv
module dqvs_dp #(
  parameter int DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dqvs_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dqvs_pkg::OUT_W-1:0]   m_tdata,
  input  dqvs_pkg::dp_cmd_t            dp_cmd,
  output dqvs_pkg::dp_status_t         dp_status
);
  import dqvs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  logic [AW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       idx;
  logic [AW-1:0]       rp;
  logic [CMD_W-1:0]    cmd_r;
  logic [VALUE_W-1:0]  val_r;
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_value;
  logic [POS_W-1:0]    res_pos;

  logic                full, empty, is_push, is_pop, match, last_idx;
  logic [AW-1:0]       head_dec, head_inc, rp_inc, tail, back;
  logic [AW-1:0]       raddr, waddr;
  logic                we;
  logic [VALUE_W-1:0]  rdata;
  logic [CW-1:0]       idx_inc;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= DEPTH_S) sum = sum - DEPTH_S;
    return sum[AW-1:0];
  endfunction

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign is_push  = (cmd_r == CMD_ADD_FRONT) || (cmd_r == CMD_ADD_BACK);
  assign is_pop   = (cmd_r == CMD_TAKE_FRONT) || (cmd_r == CMD_TAKE_BACK);
  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign rp_inc   = (rp == LAST_IDX) ? '0 : rp + 1'b1;
  assign tail     = ring_add(head, count);
  assign back     = ring_add(head, count - 1'b1);
  assign idx_inc  = idx + 1'b1;
  assign match    = (rdata == val_r);
  assign last_idx = (idx_inc == count);

  assign we    = dp_cmd.exec && is_push && !full;
  assign waddr = (cmd_r == CMD_ADD_FRONT) ? head_dec : tail;

  always_comb begin
    if (dp_cmd.search_step) raddr = rp_inc;
    else if (cmd_r == CMD_TAKE_BACK) raddr = back;
    else raddr = head;
  end

  dqvs_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    head_next  = head;
    count_next = count;
    if (dp_cmd.exec) begin
      case (cmd_r)
        CMD_ADD_FRONT: begin
          if (!full) begin
            head_next  = head_dec;
            count_next = count + 1'b1;
          end
        end
        CMD_ADD_BACK: begin
          if (!full) count_next = count + 1'b1;
        end
        CMD_TAKE_FRONT: begin
          if (!empty) begin
            head_next  = head_inc;
            count_next = count - 1'b1;
          end
        end
        CMD_TAKE_BACK: begin
          if (!empty) count_next = count - 1'b1;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      head  <= head_next;
      count <= count_next;
      if (dp_cmd.load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) begin
      cmd_r <= s_tdata[CMD_W-1:0];
      val_r <= s_tdata[CMD_W+VALUE_W-1:CMD_W];
    end
    if (dp_cmd.exec) begin
      idx <= '0;
      rp  <= head;
      if (is_push && full) begin
        res_status <= ST_FULL;
        res_value  <= '0;
        res_pos    <= '0;
      end else if (is_pop && empty) begin
        res_status <= ST_EMPTY;
        res_value  <= VALUE_NONE;
        res_pos    <= '0;
      end else if (cmd_r == CMD_SEARCH && empty) begin
        res_status <= ST_NOT_FOUND;
        res_value  <= '0;
        res_pos    <= POS_NONE;
      end else begin
        res_status <= ST_OK;
        res_value  <= '0;
        res_pos    <= '0;
      end
    end
    if (dp_cmd.pop_capture) begin
      res_value <= rdata;
    end
    if (dp_cmd.search_step) begin
      if (match) begin
        res_pos <= POS_W'(idx);
      end else if (last_idx) begin
        res_status <= ST_NOT_FOUND;
        res_pos    <= POS_NONE;
      end else begin
        idx <= idx_inc;
        rp  <= rp_inc;
      end
    end
    if (dp_cmd.load_out) begin
      m_tdata <= {4'b0, OCC_W'(count), res_pos, res_value, res_status};
    end
  end

  assign dp_status.need_read   = is_pop && !empty;
  assign dp_status.need_search = (cmd_r == CMD_SEARCH) && !empty;
  assign dp_status.search_end  = match || last_idx;
  assign dp_status.out_free    = !m_tvalid || m_tready;

endmodule

FILE: src/deque_with_value_search_core.sv
// Channel  Dir  Signals                      Word
// s_       in   s_tvalid s_tready s_tdata    command, operand_value
// m_       out  m_tvalid m_tready m_tdata    status, result_value, position, occupancy
//
// Push and unused commands pass the execute and output steps; pops add an entry store read
// (not on an empty queue), a search walks the ring with one entry store read per cycle.
// One word is worked on at a time; a new word is taken once the previous
// result sits in the output register, even while that result stalls.
// Synchronous reset empties the queue and drops any pending result.
module deque_with_value_search_core #(
  parameter int DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [2:0] command, [34:3] operand_value, [39:35] zero
  input  logic [dqvs_pkg::IN_W-1:0]         s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [1:0] status, [33:2] result_value, [42:34] position, [51:43] occupancy
  output logic [dqvs_pkg::OUT_W-1:0]        m_tdata
);
  import dqvs_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  dqvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  dqvs_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

endmodule

FILE: src/dqvs_chk.sv
module dqvs_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [dqvs_pkg::OUT_W-1:0]  m_tdata
);
  import dqvs_pkg::*;

  logic [1:0]  o_status;
  logic [31:0] o_value;
  logic [8:0]  o_pos;
  logic [8:0]  o_occ;

  assign o_status = m_tdata[1:0];
  assign o_value  = m_tdata[33:2];
  assign o_pos    = m_tdata[42:34];
  assign o_occ    = m_tdata[51:43];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_no_accept_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word present right after reset");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_status == ST_EMPTY |-> o_value == VALUE_NONE && o_occ == '0)
    else $error("empty pop reports bad value or occupancy");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_status == ST_NOT_FOUND |-> o_pos == POS_NONE)
    else $error("failed search reports a position");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in flight");

endmodule

bind deque_with_value_search_core dqvs_chk u_dqvs_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: test/deque_with_value_search_core_tb.sv
module deque_with_value_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqvs_pkg::*;

  localparam int QDEPTH = 256;
  localparam int CALM_TAIL = 60;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] val;
    bit                 hold;
  } cmd_word_t;

  typedef struct {
    status_code_t       status;
    logic [VALUE_W-1:0] result;
    logic [POS_W-1:0]   pos;
    logic [OCC_W-1:0]   occ;
  } deque_reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // [2:0] command, [34:3] operand_value, [39:35] zero
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // [1:0] status, [33:2] result_value, [42:34] position, [51:43] occupancy
  logic [OUT_W-1:0]  m_tdata;

  cmd_word_t    cmd_words[$];
  cmd_word_t    on_bus;
  deque_reply_t outcome_q[$];
  logic [VALUE_W-1:0] mirror[$];

  logic [VALUE_W-1:0] ring_store [QDEPTH];
  logic [7:0]         head;
  logic [OCC_W-1:0]   count;

  int errors = 0;
  int send_gap = 0;
  int take_gap = 0;
  int n_push = 0, n_pop = 0, n_search = 0, n_unused = 0;
  int n_full = 0, n_empty = 0, n_miss = 0, n_hit = 0, peak_occ = 0;

  deque_with_value_search_core #(.DEPTH(QDEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  task automatic apply_deque_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
    deque_reply_t r;
    bit found;
    r.status = ST_OK;
    r.result = '0;
    r.pos = '0;
    found = 1'b0;
    case (cmd)
      CMD_ADD_FRONT, CMD_ADD_BACK: begin
        n_push++;
        if (count >= QDEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else if (cmd == CMD_ADD_FRONT) begin
          head = head - 8'd1;
          ring_store[head] = val;
          count = count + 1'b1;
        end else begin
          ring_store[8'(head + count)] = val;
          count = count + 1'b1;
        end
      end
      CMD_TAKE_FRONT, CMD_TAKE_BACK: begin
        n_pop++;
        if (count == 0) begin
          r.status = ST_EMPTY;
          r.result = VALUE_NONE;
          n_empty++;
        end else if (cmd == CMD_TAKE_FRONT) begin
          r.result = ring_store[head];
          head = head + 8'd1;
          count = count - 1'b1;
        end else begin
          r.result = ring_store[8'(head + count - 1)];
          count = count - 1'b1;
        end
      end
      CMD_SEARCH: begin
        n_search++;
        r.status = ST_NOT_FOUND;
        r.pos = POS_NONE;
        for (int i = 0; i < count && !found; i++) begin
          if (ring_store[8'(head + i)] == val) begin
            r.status = ST_OK;
            r.pos = POS_W'(i);
            found = 1'b1;
          end
        end
        if (found) n_hit++;
        else n_miss++;
      end
      default: n_unused++;
    endcase
    r.occ = count;
    if (count > peak_occ) peak_occ = count;
    outcome_q.insert(outcome_q.size(), r);
  endtask

  task automatic check_reply(input logic [OUT_W-1:0] word);
    deque_reply_t want;
    status_code_t got_status;
    if (outcome_q.size() == 0) begin
      $error("result word %h with no command waiting", word);
      errors++;
      return;
    end
    want = outcome_q[0];
    outcome_q.delete(0);
    got_status = status_code_t'(word[1:0]);
    if (got_status != want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got_status);
      errors++;
    end
    if (word[33:2] != want.result) begin
      $error("result_value: expected %h, actual %h", want.result, word[33:2]);
      errors++;
    end
    if (word[42:34] != want.pos) begin
      $error("position: expected %h, actual %h", want.pos, word[42:34]);
      errors++;
    end
    if (word[51:43] != want.occ) begin
      $error("occupancy: expected %0d, actual %0d", want.occ, word[51:43]);
      errors++;
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4, 5: return VALUE_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_target();
    if (mirror.size() > 0 && $urandom_range(0, 9) < 6)
      return mirror[$urandom_range(0, mirror.size() - 1)];
    return pick_value();
  endfunction

  task automatic add_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                          input bit hold = 1'b0);
    cmd_word_t w;
    w.cmd = cmd;
    w.val = val;
    w.hold = hold;
    cmd_words.insert(cmd_words.size(), w);
    case (cmd)
      CMD_ADD_FRONT:  if (mirror.size() < QDEPTH) mirror.insert(0, val);
      CMD_ADD_BACK:   if (mirror.size() < QDEPTH) mirror.insert(mirror.size(), val);
      CMD_TAKE_FRONT: if (mirror.size() > 0) mirror.delete(0);
      CMD_TAKE_BACK:  if (mirror.size() > 0) mirror.delete(mirror.size() - 1);
      default: ;
    endcase
  endtask

  task automatic add_random(input int push_pct, input int pop_pct, input int search_pct,
                            input bit hold = 1'b0);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      add_word($urandom_range(0, 1) ? CMD_ADD_BACK : CMD_ADD_FRONT, pick_value(), hold);
    else if (r < push_pct + pop_pct)
      add_word($urandom_range(0, 1) ? CMD_TAKE_BACK : CMD_TAKE_FRONT, $urandom, hold);
    else if (r < push_pct + pop_pct + search_pct)
      add_word(CMD_SEARCH, pick_target(), hold);
    else
      add_word(CMD_W'($urandom_range(5, 7)), $urandom, hold);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      head = '0;
      count = '0;
    end else begin
      if (s_tvalid && s_tready) apply_deque_cmd(on_bus.cmd, on_bus.val);
      if (s_tvalid && !s_tready) begin
        // hold the word until taken
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (cmd_words.size() == 0 || (cmd_words[0].hold && outcome_q.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else if (cmd_words.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 16);
        s_tvalid <= 1'b0;
      end else begin
        on_bus = cmd_words[0];
        cmd_words.delete(0);
        s_tdata <= {5'b0, on_bus.val, on_bus.cmd};
        s_tvalid <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_reply(m_tdata);
      if (take_gap > 0) begin
        take_gap--;
        m_tready <= 1'b0;
      end else if (cmd_words.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
        take_gap = $urandom_range(0, 16);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    // empty queue corners, a short fill with searches and unused codes, then a drain past empty
    add_word(CMD_TAKE_FRONT, 32'hFFFF_FFFF);
    add_word(CMD_TAKE_BACK, 32'h0);
    add_word(CMD_SEARCH, 32'h0);
    add_word(CMD_ADD_FRONT, 32'h8000_0000);
    add_word(CMD_ADD_BACK, 32'h7FFF_FFFF);
    add_word(CMD_ADD_FRONT, 32'hFFFF_FFFF);
    add_word(CMD_ADD_BACK, 32'h0);
    add_word(CMD_SEARCH, 32'h7FFF_FFFF);
    add_word(CMD_SEARCH, 32'hFFFF_FFFF);
    add_word(CMD_SEARCH, 32'h0);
    add_word(CMD_SEARCH, 32'h0001_2345);
    add_word(CMD_W'(5), 32'h0);
    add_word(CMD_W'(6), 32'hA5A5_5A5A);
    add_word(CMD_W'(7), 32'hFFFF_FFFF);
    add_word(CMD_ADD_BACK, 32'hFFFF_FFFF);
    add_word(CMD_SEARCH, 32'hFFFF_FFFF);
    add_word(CMD_TAKE_BACK, 32'h0);
    add_word(CMD_TAKE_FRONT, 32'h0);
    add_word(CMD_TAKE_FRONT, 32'h0);
    add_word(CMD_TAKE_BACK, 32'h0);
    add_word(CMD_TAKE_FRONT, 32'h0);
    add_word(CMD_TAKE_BACK, 32'h0);

    // fill to full, mostly pushes, then pushes and searches on the full queue
    add_random(85, 5, 8, 1'b1);
    while (mirror.size() < QDEPTH) add_random(85, 5, 8);
    add_word(CMD_ADD_BACK, pick_value(), 1'b1);
    add_word(CMD_ADD_FRONT, pick_value());
    add_word(CMD_SEARCH, mirror[$]);
    add_word(CMD_SEARCH, mirror[0]);
    add_word(CMD_SEARCH, $urandom);
    add_word(CMD_ADD_FRONT, pick_value());
    add_word(CMD_ADD_BACK, pick_value());

    // drain to empty, mostly pops, then pops and a search on the empty queue
    add_random(5, 85, 10, 1'b1);
    while (mirror.size() > 0) add_random(5, 85, 10);
    add_word(CMD_TAKE_BACK, $urandom);
    add_word(CMD_TAKE_FRONT, $urandom);
    add_word(CMD_SEARCH, pick_value());

    // mixed traffic around a low fill level
    add_random(30, 30, 30, 1'b1);
    repeat (200) add_random(30, 30, 30);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (cmd_words.size() != 0 || s_tvalid || outcome_q.size() != 0) @(posedge clk);
    repeat (QDEPTH + 8) @(posedge clk);

    $display("covered %0d pushes, %0d pops, %0d searches, %0d unused codes; peak occupancy %0d",
             n_push, n_pop, n_search, n_unused, peak_occ);
    $display("full rejections %0d, empty pops %0d, search hits %0d, search misses %0d",
             n_full, n_empty, n_hit, n_miss);
    if (errors == 0) begin
      $display("deque_with_value_search_core test passed");
    end else begin
      $display("deque_with_value_search_core test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("deque_with_value_search_core test failed");
    $finish;
  end

endmodule
